[rtl/ddc_edid_i2c_reader_assert.svh]
// Assertion helpers for the EDID reader.
`ifndef DDC_EDID_I2C_READER_ASSERT_SVH
`define DDC_EDID_I2C_READER_ASSERT_SVH

// Checked only outside reset.
`define DDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define DDC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/ddc_pkg.sv]
package ddc_pkg;

  localparam int unsigned MAX_BYTES = 128;

  localparam logic [7:0] ADDR_WR   = 8'hA0;
  localparam logic [7:0] ADDR_RD   = 8'hA1;
  localparam logic [7:0] EDID_OFS  = 8'h00;
  localparam logic [7:0] HDR_OUTER = 8'h00;
  localparam logic [7:0] HDR_INNER = 8'hFF;
  localparam int unsigned HDR_LEN  = 8;

  localparam logic [15:0] HALF_PERIOD_RST = 16'd100;
  localparam logic [7:0]  BYTE_COUNT_RST  = 8'd128;

  localparam logic CFG_HALF_PERIOD = 1'b0;
  localparam logic CFG_BYTE_COUNT  = 1'b1;

  localparam logic [2:0] ST_NONE     = 3'd0;
  localparam logic [2:0] ST_OK       = 3'd1;
  localparam logic [2:0] ST_BUS_BUSY = 3'd2;
  localparam logic [2:0] ST_WADR_NAK = 3'd3;
  localparam logic [2:0] ST_OFS_NAK  = 3'd4;
  localparam logic [2:0] ST_RADR_NAK = 3'd5;
  localparam logic [2:0] ST_BAD_HDR  = 3'd6;

  typedef enum logic [16:0] {
    PH_IDLE    = 17'b0_0000_0000_0000_0001,
    PH_ST_END  = 17'b0_0000_0000_0000_0010,
    PH_W_LOW   = 17'b0_0000_0000_0000_0100,
    PH_W_HIGH  = 17'b0_0000_0000_0000_1000,
    PH_A_LOW   = 17'b0_0000_0000_0001_0000,
    PH_A_WAIT  = 17'b0_0000_0000_0010_0000,
    PH_A_OK    = 17'b0_0000_0000_0100_0000,
    PH_A_NAK   = 17'b0_0000_0000_1000_0000,
    PH_RS1     = 17'b0_0000_0001_0000_0000,
    PH_RS2     = 17'b0_0000_0010_0000_0000,
    PH_RS3     = 17'b0_0000_0100_0000_0000,
    PH_R_LOW   = 17'b0_0000_1000_0000_0000,
    PH_R_HIGH  = 17'b0_0001_0000_0000_0000,
    PH_RA_LOW  = 17'b0_0010_0000_0000_0000,
    PH_RA_WAIT = 17'b0_0100_0000_0000_0000,
    PH_SP1     = 17'b0_1000_0000_0000_0000,
    PH_SP2     = 17'b1_0000_0000_0000_0000
  } phase_e;

endpackage

[rtl/ddc_edid_i2c_reader.sv]
// Ticked I2C master reading a display EDID block. Every input beat is either one time
// tick with the sampled SDA/SCL levels (action 0) or a start command (action 1), and it
// yields exactly one output beat carrying the line drives after that beat, an optional
// received byte with its index, and a done flag with the final status. The block takes
// one input beat per clock while the output is not stalled, and its output beat appears
// in an output register in the cycle after acceptance; a new input is taken in the same
// cycle the previous result leaves. Bus timing is counted in input ticks (half_period_ticks
// per half SCL period), not clocks. Config is written via the always-ready cfg channel.
module ddc_edid_i2c_reader
  import ddc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic        sda_in_i,
  input  logic        scl_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        scl_drive_o,
  output logic        sda_drive_o,
  output logic        byte_valid_o,
  output logic [7:0]  byte_value_o,
  output logic [6:0]  byte_index_o,
  output logic        done_res_o,
  output logic [2:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  `include "ddc_edid_i2c_reader_assert.svh"

  logic [15:0] half_q;
  logic [7:0]  count_q;

  phase_e      phase_q, phase_d;
  logic [15:0] tick_q, tick_d;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  byte_cnt_q, byte_cnt_d;
  logic        hdr_good_q, hdr_good_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;

  logic        out_valid_q;
  logic        bvalid_q, bvalid_d;
  logic [7:0]  bvalue_q, bvalue_d;
  logic [6:0]  bindex_q, bindex_d;
  logic        done_q, done_d;
  logic [2:0]  status_q, status_d;

  logic        in_fire;
  logic [7:0]  eff_count;
  logic [15:0] hp;
  logic [15:0] tick_inc;
  logic [3:0]  bit_inc;
  logic [7:0]  byte_inc;
  logic [7:0]  shift_in;
  logic [7:0]  want;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign eff_count = (count_q < 8'(MAX_BYTES)) ? count_q : 8'(MAX_BYTES);
  assign hp        = (half_q == '0) ? 16'd1 : half_q;
  assign tick_inc  = tick_q + 16'd1;
  assign bit_inc   = bit_q + 4'd1;
  assign byte_inc  = byte_cnt_q + 8'd1;
  assign shift_in  = {shift_q[6:0], sda_in_i};
  assign want      = (byte_cnt_q == 8'd0 || byte_cnt_q == 8'(HDR_LEN - 1)) ? HDR_OUTER
                                                                          : HDR_INNER;

  always_comb begin
    phase_d    = phase_q;
    tick_d     = tick_q;
    bit_d      = bit_q;
    shift_d    = shift_q;
    byte_cnt_d = byte_cnt_q;
    hdr_good_d = hdr_good_q;
    scl_d      = scl_q;
    sda_d      = sda_q;
    bvalid_d   = 1'b0;
    bvalue_d   = '0;
    bindex_d   = '0;
    done_d     = 1'b0;
    status_d   = ST_NONE;

    if (action_i) begin
      if (phase_q == PH_IDLE) begin
        if (!sda_in_i || !scl_in_i) begin
          done_d   = 1'b1;
          status_d = ST_BUS_BUSY;
        end else begin
          hdr_good_d = 1'b1;
          byte_cnt_d = '0;
          bit_d      = '0;
          tick_d     = '0;
          sda_d      = 1'b0;
          shift_d    = ADDR_WR;
          phase_d    = PH_ST_END;
        end
      end
    end else if (phase_q != PH_IDLE) begin
      tick_d = tick_inc;
      if (tick_inc >= hp) begin
        tick_d = '0;
        unique case (phase_q)
          PH_ST_END: begin
            bit_d   = '0;
            scl_d   = 1'b0;
            sda_d   = shift_q[7];
            phase_d = PH_W_LOW;
          end
          PH_W_LOW: begin
            scl_d   = 1'b1;
            phase_d = PH_W_HIGH;
          end
          PH_W_HIGH: begin
            bit_d = bit_inc;
            scl_d = 1'b0;
            if (bit_inc < 4'd8) begin
              sda_d   = shift_q[3'd7 - bit_inc[2:0]];
              phase_d = PH_W_LOW;
            end else begin
              sda_d   = 1'b1;
              phase_d = PH_A_LOW;
            end
          end
          PH_A_LOW: begin
            scl_d   = 1'b1;
            phase_d = PH_A_WAIT;
          end
          PH_A_WAIT: begin
            if (scl_in_i) phase_d = sda_in_i ? PH_A_NAK : PH_A_OK;
          end
          PH_A_NAK: begin
            if (shift_q == EDID_OFS) begin
              done_d   = 1'b1;
              status_d = ST_OFS_NAK;
              phase_d  = PH_IDLE;
            end else begin
              scl_d   = 1'b0;
              sda_d   = 1'b0;
              bit_d   = {1'b0, (shift_q == ADDR_WR) ? ST_WADR_NAK : ST_RADR_NAK};
              phase_d = PH_SP1;
            end
          end
          PH_A_OK: begin
            if (shift_q == ADDR_WR) begin
              shift_d = EDID_OFS;
              bit_d   = '0;
              scl_d   = 1'b0;
              sda_d   = EDID_OFS[7];
              phase_d = PH_W_LOW;
            end else if (shift_q == EDID_OFS) begin
              scl_d   = 1'b0;
              phase_d = PH_RS1;
            end else if (eff_count == '0) begin
              scl_d   = 1'b0;
              sda_d   = 1'b0;
              bit_d   = {1'b0, ST_OK};
              phase_d = PH_SP1;
            end else begin
              scl_d   = 1'b0;
              sda_d   = 1'b1;
              shift_d = '0;
              bit_d   = '0;
              phase_d = PH_R_LOW;
            end
          end
          PH_RS1: begin
            sda_d   = 1'b1;
            phase_d = PH_RS2;
          end
          PH_RS2: begin
            scl_d   = 1'b1;
            phase_d = PH_RS3;
          end
          PH_RS3: begin
            if (!sda_in_i || !scl_in_i) begin
              done_d   = 1'b1;
              status_d = ST_BUS_BUSY;
              phase_d  = PH_IDLE;
            end else begin
              sda_d   = 1'b0;
              shift_d = ADDR_RD;
              phase_d = PH_ST_END;
            end
          end
          PH_R_LOW: begin
            scl_d   = 1'b1;
            phase_d = PH_R_HIGH;
          end
          PH_R_HIGH: begin
            shift_d = shift_in;
            bit_d   = bit_inc;
            scl_d   = 1'b0;
            if (bit_inc < 4'd8) begin
              phase_d = PH_R_LOW;
            end else begin
              sda_d   = ({1'b0, byte_cnt_q} + 9'd1 < {1'b0, eff_count}) ? 1'b0 : 1'b1;
              phase_d = PH_RA_LOW;
            end
          end
          PH_RA_LOW: begin
            scl_d   = 1'b1;
            phase_d = PH_RA_WAIT;
          end
          PH_RA_WAIT: begin
            if (scl_in_i) begin
              bvalid_d = 1'b1;
              bvalue_d = shift_q;
              bindex_d = byte_cnt_q[6:0];
              if (byte_cnt_q < 8'(HDR_LEN) && shift_q != want) hdr_good_d = 1'b0;
              byte_cnt_d = byte_inc;
              scl_d      = 1'b0;
              if (byte_inc < eff_count) begin
                sda_d   = 1'b1;
                shift_d = '0;
                bit_d   = '0;
                phase_d = PH_R_LOW;
              end else begin
                sda_d   = 1'b0;
                bit_d   = {1'b0, ST_OK};
                phase_d = PH_SP1;
              end
            end
          end
          PH_SP1: begin
            scl_d   = 1'b1;
            phase_d = PH_SP2;
          end
          PH_SP2: begin
            sda_d   = 1'b1;
            done_d  = 1'b1;
            phase_d = PH_IDLE;
            if (bit_q == {1'b0, ST_OK}) begin
              status_d = (hdr_good_q && byte_cnt_q >= 8'(HDR_LEN)) ? ST_OK : ST_BAD_HDR;
            end else begin
              status_d = bit_q[2:0];
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q  <= HALF_PERIOD_RST;
      count_q <= BYTE_COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_HALF_PERIOD: half_q  <= cfg_data_i;
        CFG_BYTE_COUNT:  count_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      tick_q     <= '0;
      bit_q      <= '0;
      shift_q    <= '0;
      byte_cnt_q <= '0;
      hdr_good_q <= 1'b1;
      scl_q      <= 1'b1;
      sda_q      <= 1'b1;
    end else if (in_fire) begin
      phase_q    <= phase_d;
      tick_q     <= tick_d;
      bit_q      <= bit_d;
      shift_q    <= shift_d;
      byte_cnt_q <= byte_cnt_d;
      hdr_good_q <= hdr_good_d;
      scl_q      <= scl_d;
      sda_q      <= sda_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      bvalid_q <= bvalid_d;
      bvalue_q <= bvalue_d;
      bindex_q <= bindex_d;
      done_q   <= done_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign scl_drive_o  = scl_q;
  assign sda_drive_o  = sda_q;
  assign byte_valid_o = bvalid_q;
  assign byte_value_o = bvalue_q;
  assign byte_index_o = bindex_q;
  assign done_res_o   = done_q;
  assign status_o     = status_q;

  `DDC_ASSERT(a_done_status, out_valid_q |-> ((status_q != ST_NONE) == done_q), "status without done")
  `DDC_ASSERT(a_byte_not_done, out_valid_q && bvalid_q |-> !done_q, "byte and done in one beat")
  `DDC_ASSERT(a_done_idle, in_fire |=> (!done_q || phase_q == PH_IDLE), "done while not idle")
  `DDC_ASSERT(a_bit_range, bit_q <= 4'd8, "bit counter out of range")

endmodule
